// ===== rtl/core/rccl_pkg.sv =====
package rccl_pkg;

    localparam int ADC_BITS = 12;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int IR_W     = 12;
    localparam int DUTY_W   = 10;
    localparam int SPEED_W  = 2;
    localparam int STEER_W  = 3;
    localparam int DEC_W    = 5;
    localparam int BLINK_W  = 11;
    localparam int DAFT_W   = 4;
    localparam int BAFT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [IR_W-1:0] ADC_MASK = IR_W'((64'd1 << ADC_BITS) - 64'd1);

    localparam logic [DEC_W-1:0]   DEC_MAX   = '1;
    localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

    localparam logic [DUTY_W-1:0] FULL_SCALE = 10'd1000;
    localparam logic [DUTY_W-1:0] CMD_IDLE   = 10'd800;
    localparam logic [DUTY_W-1:0] CMD_SLOW   = 10'd500;
    localparam logic [DUTY_W-1:0] CMD_CRUISE = 10'd900;

    localparam logic [IR_W-1:0]   THRESH_RST = 12'd1500;
    localparam logic [DAFT_W-1:0] DAFT_RST   = 4'd10;
    localparam logic [BAFT_W-1:0] BAFT_RST   = 10'd500;

    localparam logic [SPEED_W-1:0] SPEED_TOP = '1;
    localparam logic signed [STEER_W-1:0] STEER_MAX = 3'sd3;
    localparam logic signed [STEER_W-1:0] STEER_MIN = -3'sd3;
    localparam logic [STEER_W-1:0] STEER_BIAS = 3'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BYTE = 2'd0,
        FUNC_IR   = 2'd1,
        FUNC_TICK = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 2'd0,
        CFG_DECIDE = 2'd1,
        CFG_BLINK  = 2'd2
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = "[";
    localparam logic [BYTE_W-1:0] KEY_UP      = "A";
    localparam logic [BYTE_W-1:0] KEY_DOWN    = "B";
    localparam logic [BYTE_W-1:0] KEY_RIGHT   = "C";
    localparam logic [BYTE_W-1:0] KEY_LEFT    = "D";
    localparam logic [BYTE_W-1:0] CH_M_UC = "M";
    localparam logic [BYTE_W-1:0] CH_M_LC = "m";
    localparam logic [BYTE_W-1:0] CH_A_UC = "A";
    localparam logic [BYTE_W-1:0] CH_A_LC = "a";
    localparam logic [BYTE_W-1:0] CH_L_UC = "L";
    localparam logic [BYTE_W-1:0] CH_L_LC = "l";
    localparam logic [BYTE_W-1:0] CH_Q_UC = "Q";
    localparam logic [BYTE_W-1:0] CH_Q_LC = "q";
    localparam logic [BYTE_W-1:0] CH_R_UC = "R";
    localparam logic [BYTE_W-1:0] CH_R_LC = "r";
    localparam logic [BYTE_W-1:0] CH_E_UC = "E";
    localparam logic [BYTE_W-1:0] CH_E_LC = "e";
    localparam logic [BYTE_W-1:0] CH_F_UC = "F";
    localparam logic [BYTE_W-1:0] CH_F_LC = "f";
    localparam logic [BYTE_W-1:0] CH_W_UC = "W";
    localparam logic [BYTE_W-1:0] CH_W_LC = "w";
    localparam logic [BYTE_W-1:0] CH_B_UC = "B";
    localparam logic [BYTE_W-1:0] CH_B_LC = "b";
    localparam logic [BYTE_W-1:0] CH_S_UC = "S";
    localparam logic [BYTE_W-1:0] CH_S_LC = "s";

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] rx_byte;
        logic [IR_W-1:0]   left_ir;
        logic [IR_W-1:0]   right_ir;
    } t_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [DUTY_W-1:0] left_cmd;
        logic [DUTY_W-1:0] right_cmd;
        logic              left_latch;
        logic              right_latch;
        logic              left_pin;
        logic              right_pin;
        logic              led;
        logic              auto_mode;
    } t_drive;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              left_dir_pin;
        logic              right_dir_pin;
        logic              led_on;
        logic              auto_on;
    } t_result;

    function automatic logic [DUTY_W-1:0] speed_cmd(input logic [SPEED_W-1:0] lvl);
        logic [DUTY_W-1:0] v;
        case (lvl)
            2'd0:    v = 10'd450;
            2'd1:    v = 10'd600;
            2'd2:    v = 10'd750;
            default: v = 10'd900;
        endcase
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] steer_left_cmd(input logic [STEER_W-1:0] idx);
        logic [DUTY_W-1:0] v;
        case (idx)
            3'd0:    v = 10'd400;
            3'd1:    v = 10'd500;
            3'd2:    v = 10'd600;
            3'd3:    v = 10'd700;
            default: v = 10'd800;
        endcase
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] steer_right_cmd(input logic [STEER_W-1:0] idx);
        logic [DUTY_W-1:0] v;
        case (idx)
            3'd0, 3'd1, 3'd2: v = 10'd800;
            3'd3:    v = 10'd700;
            3'd4:    v = 10'd600;
            3'd5:    v = 10'd500;
            default: v = 10'd400;
        endcase
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input logic latch,
                                                   input logic [DUTY_W-1:0] cmd);
        logic [DUTY_W-1:0] v;
        if (!latch) begin
            v = cmd;
        end else if (cmd > FULL_SCALE) begin
            v = cmd - FULL_SCALE;
        end else begin
            v = FULL_SCALE - cmd;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/rccl_if.sv =====
interface rccl_in_if import rccl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
    logic [IR_W-1:0]   left_ir;
    logic [IR_W-1:0]   right_ir;

    modport source (output valid, output func, output rx_byte, output left_ir,
                    output right_ir, input ready);
    modport sink   (input valid, input func, input rx_byte, input left_ir,
                    input right_ir, output ready);
endinterface

interface rccl_out_if import rccl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_dir_pin;
    logic              right_dir_pin;
    logic              led_on;
    logic              auto_on;

    modport source (output valid, output left_duty, output right_duty,
                    output left_dir_pin, output right_dir_pin, output led_on,
                    output auto_on, input ready);
    modport sink   (input valid, input left_duty, input right_duty,
                    input left_dir_pin, input right_dir_pin, input led_on,
                    input auto_on, output ready);
endinterface

interface rccl_cfg_if import rccl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rccl_ctrl.sv =====
module rccl_ctrl import rccl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_take,
    input  t_item   i_item,
    output t_drive  o_drive
);

    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_OPEN  = 3'b010,
        ESC_ARROW = 3'b100
    } t_esc;

    t_esc                       r_esc, n_esc;
    logic                       r_auto, n_auto;
    logic [SPEED_W-1:0]         r_speed, n_speed;
    logic signed [STEER_W-1:0]  r_steer, n_steer;
    logic [DUTY_W-1:0]          r_lcmd, n_lcmd;
    logic [DUTY_W-1:0]          r_rcmd, n_rcmd;
    logic                       r_llatch, n_llatch;
    logic                       r_rlatch, n_rlatch;
    logic                       r_lpin, n_lpin;
    logic                       r_rpin, n_rpin;
    logic [IR_W-1:0]            r_ir_l, n_ir_l;
    logic [IR_W-1:0]            r_ir_r, n_ir_r;
    logic [DEC_W-1:0]           r_dec, n_dec;
    logic [BLINK_W-1:0]         r_blink, n_blink;
    logic                       r_led, n_led;
    logic [IR_W-1:0]            r_thresh;
    logic [DAFT_W-1:0]          r_daft;
    logic [BAFT_W-1:0]          r_baft;

    logic [BYTE_W-1:0]  b;
    logic [STEER_W-1:0] steer_idx;
    logic               l_on, l_off, r_on, r_off;

    assign b     = i_item.rx_byte;
    assign l_on  = r_ir_l > r_thresh;
    assign l_off = r_ir_l < r_thresh;
    assign r_on  = r_ir_r > r_thresh;
    assign r_off = r_ir_r < r_thresh;

    always_comb begin
        n_esc    = r_esc;
        n_auto   = r_auto;
        n_speed  = r_speed;
        n_steer  = r_steer;
        n_lcmd   = r_lcmd;
        n_rcmd   = r_rcmd;
        n_llatch = r_llatch;
        n_rlatch = r_rlatch;
        n_lpin   = r_lpin;
        n_rpin   = r_rpin;
        n_ir_l   = r_ir_l;
        n_ir_r   = r_ir_r;
        n_dec    = r_dec;
        n_blink  = r_blink;
        n_led    = r_led;
        steer_idx = $unsigned(r_steer) + STEER_BIAS;
        case (i_item.func)
            FUNC_BYTE: begin
                unique case (r_esc)
                    ESC_OPEN: begin
                        n_esc = (b == CH_LBRACKET) ? ESC_ARROW : ESC_IDLE;
                    end
                    ESC_ARROW: begin
                        n_esc = ESC_IDLE;
                        case (b)
                            KEY_UP: begin
                                if (r_speed != SPEED_TOP) n_speed = r_speed + 2'd1;
                                n_lcmd = speed_cmd(n_speed);
                                n_rcmd = speed_cmd(n_speed);
                            end
                            KEY_DOWN: begin
                                if (r_speed != '0) n_speed = r_speed - 2'd1;
                                n_lcmd = speed_cmd(n_speed);
                                n_rcmd = speed_cmd(n_speed);
                            end
                            KEY_RIGHT: begin
                                if (r_steer != STEER_MAX) n_steer = r_steer + 3'sd1;
                                steer_idx = $unsigned(n_steer) + STEER_BIAS;
                                n_lcmd = steer_left_cmd(steer_idx);
                                n_rcmd = steer_right_cmd(steer_idx);
                            end
                            KEY_LEFT: begin
                                if (r_steer != STEER_MIN) n_steer = r_steer - 3'sd1;
                                steer_idx = $unsigned(n_steer) + STEER_BIAS;
                                n_lcmd = steer_left_cmd(steer_idx);
                                n_rcmd = steer_right_cmd(steer_idx);
                            end
                            default: ;
                        endcase
                    end
                    default: begin
                        n_esc = ESC_IDLE;
                        if (b == CH_ESC) begin
                            n_esc = ESC_OPEN;
                        end else begin
                            case (b) inside
                                CH_M_UC, CH_M_LC: begin
                                    n_led  = 1'b1;
                                    n_auto = 1'b0;
                                end
                                CH_A_UC, CH_A_LC: n_auto = 1'b1;
                                CH_L_UC, CH_L_LC, CH_Q_UC, CH_Q_LC: begin
                                    if (!r_auto) begin
                                        n_lcmd = CMD_SLOW;
                                        n_rcmd = CMD_IDLE;
                                    end
                                end
                                CH_R_UC, CH_R_LC, CH_E_UC, CH_E_LC: begin
                                    if (!r_auto) begin
                                        n_lcmd = CMD_IDLE;
                                        n_rcmd = CMD_SLOW;
                                    end
                                end
                                CH_F_UC, CH_F_LC, CH_W_UC, CH_W_LC: begin
                                    if (!r_auto) begin
                                        n_lpin   = 1'b0;
                                        n_rpin   = 1'b1;
                                        n_llatch = 1'b0;
                                        n_rlatch = 1'b1;
                                        n_lcmd   = FULL_SCALE;
                                        n_rcmd   = FULL_SCALE;
                                    end
                                end
                                CH_B_UC, CH_B_LC: begin
                                    if (!r_auto) begin
                                        n_lpin   = 1'b1;
                                        n_rpin   = 1'b0;
                                        n_llatch = 1'b1;
                                        n_rlatch = 1'b0;
                                        n_lcmd   = FULL_SCALE;
                                        n_rcmd   = FULL_SCALE;
                                    end
                                end
                                CH_S_UC, CH_S_LC: begin
                                    if (!r_auto) begin
                                        n_llatch = r_lpin;
                                        n_rlatch = r_rpin;
                                        n_lcmd   = r_lpin ? FULL_SCALE : '0;
                                        n_rcmd   = r_rpin ? FULL_SCALE : '0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
            FUNC_IR: begin
                n_ir_l = i_item.left_ir & ADC_MASK;
                n_ir_r = i_item.right_ir & ADC_MASK;
            end
            FUNC_TICK: begin
                if (r_dec != DEC_MAX) n_dec = r_dec + 5'd1;
                if (r_blink != BLINK_MAX) n_blink = r_blink + 11'd1;
                if (r_auto && (n_dec > {1'b0, r_daft})) begin
                    if ((l_off && r_off) || (l_on && r_on)) begin
                        n_lcmd = CMD_CRUISE;
                        n_rcmd = CMD_CRUISE;
                    end else if (l_on && r_off) begin
                        n_lcmd = CMD_SLOW;
                        n_rcmd = CMD_IDLE;
                    end else if (l_off && r_on) begin
                        n_lcmd = CMD_IDLE;
                        n_rcmd = CMD_SLOW;
                    end
                    n_dec = '0;
                end
                if (r_auto && (n_blink > {1'b0, r_baft})) begin
                    n_led   = ~r_led;
                    n_blink = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= ESC_IDLE;
            r_auto   <= 1'b0;
            r_speed  <= '0;
            r_steer  <= '0;
            r_lcmd   <= CMD_IDLE;
            r_rcmd   <= CMD_IDLE;
            r_llatch <= 1'b0;
            r_rlatch <= 1'b0;
            r_lpin   <= 1'b0;
            r_rpin   <= 1'b1;
            r_ir_l   <= '0;
            r_ir_r   <= '0;
            r_dec    <= '0;
            r_blink  <= '0;
            r_led    <= 1'b0;
        end else if (i_take) begin
            r_esc    <= n_esc;
            r_auto   <= n_auto;
            r_speed  <= n_speed;
            r_steer  <= n_steer;
            r_lcmd   <= n_lcmd;
            r_rcmd   <= n_rcmd;
            r_llatch <= n_llatch;
            r_rlatch <= n_rlatch;
            r_lpin   <= n_lpin;
            r_rpin   <= n_rpin;
            r_ir_l   <= n_ir_l;
            r_ir_r   <= n_ir_r;
            r_dec    <= n_dec;
            r_blink  <= n_blink;
            r_led    <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_daft   <= DAFT_RST;
            r_baft   <= BAFT_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_THRESH: r_thresh <= i_cfg.data[IR_W-1:0];
                CFG_DECIDE: r_daft   <= i_cfg.data[DAFT_W-1:0];
                CFG_BLINK:  r_baft   <= i_cfg.data[BAFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_drive = '{left_cmd:    n_lcmd,
                       right_cmd:   n_rcmd,
                       left_latch:  n_llatch,
                       right_latch: n_rlatch,
                       left_pin:    n_lpin,
                       right_pin:   n_rpin,
                       led:         n_led,
                       auto_mode:   n_auto};

endmodule

// ===== rtl/core/rccl_outreg.sv =====
module rccl_outreg import rccl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_drive  i_drive,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.left_duty     <= duty_of(i_drive.left_latch, i_drive.left_cmd);
            r_res.right_duty    <= duty_of(i_drive.right_latch, i_drive.right_cmd);
            r_res.left_dir_pin  <= i_drive.left_pin;
            r_res.right_dir_pin <= i_drive.right_pin;
            r_res.led_on        <= i_drive.led;
            r_res.auto_on       <= i_drive.auto_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/rc_car_command_and_line_follow.sv =====
// Two-motor drive controller with command parsing and line following.
// Channels:
//   i_in  : items, func 0 command byte, 1 IR sample pair, 2 timer tick,
//           3 reports the present outputs unchanged.
//   o_out : one result per item: both duties in per-mille, direction pins,
//           LED level and mode.
//   i_cfg : register writes, index 0 line threshold, 1 decide count,
//           2 blink count; always ready, write only while idle.
// Latency: the result of an item is valid the cycle after its transfer.
// Throughput: one item per cycle while o_out accepts results; the state
// update and the result register load both happen on the item transfer.
// Reset (synchronous, active low): manual mode, commands 800/800, pins
// left 0 right 1, counters and LED cleared, registers 1500/10/500,
// no result pending.
// Stall: a held result keeps the next item out; one transfer can enter in
// the same cycle the pending result leaves.
module rc_car_command_and_line_follow import rccl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rccl_in_if.sink     i_in,
    rccl_out_if.source  o_out,
    rccl_cfg_if.sink    i_cfg
);

    logic    take;
    logic    free;
    t_item   item;
    t_cfg_wr cfg_wr;
    t_drive  drive;
    t_result res;

    assign i_in.ready  = free;
    assign take        = i_in.valid && free;
    assign i_cfg.ready = 1'b1;

    assign item   = '{func:     i_in.func,
                      rx_byte:  i_in.rx_byte,
                      left_ir:  i_in.left_ir,
                      right_ir: i_in.right_ir};
    assign cfg_wr = '{we: i_cfg.valid, idx: i_cfg.index, data: i_cfg.data};

    rccl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_take  (take),
        .i_item  (item),
        .o_drive (drive)
    );

    rccl_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_drive (drive),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_free  (free),
        .o_res   (res)
    );

    assign o_out.left_duty     = res.left_duty;
    assign o_out.right_duty    = res.right_duty;
    assign o_out.left_dir_pin  = res.left_dir_pin;
    assign o_out.right_dir_pin = res.right_dir_pin;
    assign o_out.led_on        = res.led_on;
    assign o_out.auto_on       = res.auto_on;

endmodule

// ===== rtl/core/rccl_check.sv =====
module rccl_check import rccl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_left_duty,
    input logic [DUTY_W-1:0] i_right_duty
);

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after input transfer");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked with result stage free");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left_duty <= FULL_SCALE) && (i_right_duty <= FULL_SCALE))
        else $error("duty above full scale");

endmodule

bind rc_car_command_and_line_follow rccl_check u_rccl_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_left_duty  (o_out.left_duty),
    .i_right_duty (o_out.right_duty)
);

// ===== tb/rc_car_command_and_line_follow_test.sv =====
`timescale 1ns / 1ps

module rc_car_command_and_line_follow_test;
    import rccl_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class drive_scoreboard;
        logic [IR_W-1:0]   thresh;
        logic [DAFT_W-1:0] decide_lim;
        logic [BAFT_W-1:0] blink_lim;
        logic [1:0]        esc_phase;
        bit                auto_mode;
        int                speed_lvl;
        int                steer_lvl;
        logic [DUTY_W-1:0] left_cmd;
        logic [DUTY_W-1:0] right_cmd;
        bit                left_latch;
        bit                right_latch;
        bit                left_pin;
        bit                right_pin;
        logic [IR_W-1:0]   left_sample;
        logic [IR_W-1:0]   right_sample;
        int                decide_cnt;
        int                blink_cnt;
        bit                led;
        logic [DUTY_W-1:0] speed_tab [4];
        logic [DUTY_W-1:0] steer_l_tab [7];
        logic [DUTY_W-1:0] steer_r_tab [7];
        t_result           drive_q[$];
        int                errors;

        function new();
            speed_tab   = '{10'd450, 10'd600, 10'd750, 10'd900};
            steer_l_tab = '{10'd400, 10'd500, 10'd600, 10'd700, 10'd800, 10'd800, 10'd800};
            steer_r_tab = '{10'd800, 10'd800, 10'd800, 10'd700, 10'd600, 10'd500, 10'd400};
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            thresh = 12'd1500;
            decide_lim = 4'd10;
            blink_lim = 10'd500;
            esc_phase = 2'd0;
            auto_mode = 0;
            speed_lvl = 0;
            steer_lvl = 0;
            left_cmd = 10'd800;
            right_cmd = 10'd800;
            left_latch = 0;
            right_latch = 0;
            left_pin = 0;
            right_pin = 1;
            left_sample = '0;
            right_sample = '0;
            decide_cnt = 0;
            blink_cnt = 0;
            led = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESH: thresh = val;
                CFG_DECIDE: decide_lim = val[DAFT_W-1:0];
                CFG_BLINK:  blink_lim = val[BAFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void load(logic [DUTY_W-1:0] l, logic [DUTY_W-1:0] r);
            left_cmd = l;
            right_cmd = r;
        endfunction

        function logic [DUTY_W-1:0] duty(bit lat, logic [DUTY_W-1:0] c);
            int base;
            base = lat ? 1000 : 0;
            return (base >= int'(c)) ? DUTY_W'(base - int'(c)) : DUTY_W'(int'(c) - base);
        endfunction

        function void take_arrow(logic [BYTE_W-1:0] b);
            if (b == KEY_UP || b == KEY_DOWN) begin
                if (b == KEY_UP) begin
                    if (speed_lvl < 3) speed_lvl++;
                end else begin
                    if (speed_lvl > 0) speed_lvl--;
                end
                load(speed_tab[speed_lvl], speed_tab[speed_lvl]);
            end else if (b == KEY_RIGHT || b == KEY_LEFT) begin
                if (b == KEY_RIGHT) begin
                    if (steer_lvl < 3) steer_lvl++;
                end else begin
                    if (steer_lvl > -3) steer_lvl--;
                end
                load(steer_l_tab[steer_lvl + 3], steer_r_tab[steer_lvl + 3]);
            end
        endfunction

        function void take_letter(logic [BYTE_W-1:0] b);
            if (b == CH_M_UC || b == CH_M_LC) begin
                led = 1;
                auto_mode = 0;
            end else if (b == CH_A_UC || b == CH_A_LC) begin
                auto_mode = 1;
            end else if (auto_mode) begin
                return;
            end else if (b == CH_L_UC || b == CH_L_LC || b == CH_Q_UC || b == CH_Q_LC) begin
                load(10'd500, 10'd800);
            end else if (b == CH_R_UC || b == CH_R_LC || b == CH_E_UC || b == CH_E_LC) begin
                load(10'd800, 10'd500);
            end else if (b == CH_F_UC || b == CH_F_LC || b == CH_W_UC || b == CH_W_LC) begin
                left_pin = 0;
                right_pin = 1;
                left_latch = 0;
                right_latch = 1;
                load(10'd1000, 10'd1000);
            end else if (b == CH_B_UC || b == CH_B_LC) begin
                left_pin = 1;
                right_pin = 0;
                left_latch = 1;
                right_latch = 0;
                load(10'd1000, 10'd1000);
            end else if (b == CH_S_UC || b == CH_S_LC) begin
                left_latch = left_pin;
                right_latch = right_pin;
                load(left_latch ? 10'd1000 : 10'd0, right_latch ? 10'd1000 : 10'd0);
            end
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            if (esc_phase == 2'd1) begin
                esc_phase = (b == CH_LBRACKET) ? 2'd2 : 2'd0;
            end else if (esc_phase == 2'd2) begin
                esc_phase = 2'd0;
                take_arrow(b);
            end else begin
                esc_phase = 2'd0;
                if (b == CH_ESC) esc_phase = 2'd1;
                else take_letter(b);
            end
        endfunction

        function void take_tick();
            logic [IR_W-1:0] l;
            logic [IR_W-1:0] r;
            logic [IR_W-1:0] t;
            l = left_sample;
            r = right_sample;
            t = thresh;
            if (decide_cnt < 31) decide_cnt++;
            if (blink_cnt < 2047) blink_cnt++;
            if (auto_mode && decide_cnt > int'(decide_lim)) begin
                if ((l < t && r < t) || (l > t && r > t)) load(10'd900, 10'd900);
                else if (l > t && r < t) load(10'd500, 10'd800);
                else if (l < t && r > t) load(10'd800, 10'd500);
                decide_cnt = 0;
            end
            if (auto_mode && blink_cnt > int'(blink_lim)) begin
                led = !led;
                blink_cnt = 0;
            end
        endfunction

        function void note_item(t_item it);
            t_result res;
            case (it.func)
                FUNC_BYTE: take_byte(it.rx_byte);
                FUNC_IR: begin
                    left_sample = it.left_ir & ADC_MASK;
                    right_sample = it.right_ir & ADC_MASK;
                end
                FUNC_TICK: take_tick();
                default: ;
            endcase
            res.left_duty = duty(left_latch, left_cmd);
            res.right_duty = duty(right_latch, right_cmd);
            res.left_dir_pin = left_pin;
            res.right_dir_pin = right_pin;
            res.led_on = led;
            res.auto_on = auto_mode;
            drive_q.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (drive_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing pending: %p", $realtime, got);
                return;
            end
            want = drive_q.pop_front();
            if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
                got.left_dir_pin !== want.left_dir_pin ||
                got.right_dir_pin !== want.right_dir_pin ||
                got.led_on !== want.led_on || got.auto_on !== want.auto_on) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch duty %0d/%0d pins %b%b led %b auto %b, expected %0d/%0d pins %b%b led %b auto %b",
                             $realtime, got.left_duty, got.right_duty, got.left_dir_pin,
                             got.right_dir_pin, got.led_on, got.auto_on, want.left_duty,
                             want.right_duty, want.left_dir_pin, want.right_dir_pin,
                             want.led_on, want.auto_on);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rccl_in_if  in_if ();
    rccl_out_if out_if ();
    rccl_cfg_if cfg_if ();

    rc_car_command_and_line_follow u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    drive_scoreboard sb;
    int n_sent;
    int n_results;
    int burst_left;

    logic [BYTE_W-1:0] letter_set [20] = '{
        CH_M_UC, CH_M_LC, CH_A_UC, CH_A_LC, CH_L_UC, CH_L_LC, CH_Q_UC, CH_Q_LC,
        CH_R_UC, CH_R_LC, CH_E_UC, CH_E_LC, CH_F_UC, CH_F_LC, CH_W_UC, CH_W_LC,
        CH_B_UC, CH_B_LC, CH_S_UC, CH_S_LC
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(64'd10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.left_duty = out_if.left_duty;
            got.right_duty = out_if.right_duty;
            got.left_dir_pin = out_if.left_dir_pin;
            got.right_dir_pin = out_if.right_dir_pin;
            got.led_on = out_if.led_on;
            got.auto_on = out_if.auto_on;
            sb.check_result(got);
            n_results++;
        end
    end

    // result side: segments of steady, random and on/off ready, one long hold-off
    initial begin
        int seg;
        int mode;
        int on_len;
        int off_len;
        bit held;
        held = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_results >= 200) begin
                held = 1;
                out_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            seg = $urandom_range(10, 120);
            mode = $urandom_range(0, 2);
            on_len = $urandom_range(1, 6);
            off_len = $urandom_range(1, 4);
            for (int c = 0; c < seg; c++) begin
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ((c % (on_len + off_len)) < on_len);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic t_item make_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                                        logic [IR_W-1:0] l, logic [IR_W-1:0] r);
        t_item it;
        it.func = f;
        it.rx_byte = b;
        it.left_ir = l;
        it.right_ir = r;
        return it;
    endfunction

    task automatic send(t_item it);
        in_if.valid <= 1'b1;
        in_if.func <= it.func;
        in_if.rx_byte <= it.rx_byte;
        in_if.left_ir <= it.left_ir;
        in_if.right_ir <= it.right_ir;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic offer(t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
        end
        burst_left--;
        send(it);
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        offer(make_item(FUNC_BYTE, b, IR_W'($urandom), IR_W'($urandom)));
    endtask

    task automatic send_ir(logic [IR_W-1:0] l, logic [IR_W-1:0] r);
        offer(make_item(FUNC_IR, BYTE_W'($urandom), l, r));
    endtask

    task automatic send_tick();
        offer(make_item(FUNC_TICK, BYTE_W'($urandom), IR_W'($urandom), IR_W'($urandom)));
    endtask

    task automatic send_none();
        offer(make_item(FUNC_NONE, BYTE_W'($urandom), IR_W'($urandom), IR_W'($urandom)));
    endtask

    task automatic send_arrow(logic [BYTE_W-1:0] key);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(key);
    endtask

    function automatic logic [IR_W-1:0] pick_ir();
        int t;
        t = int'(sb.thresh);
        case ($urandom_range(0, 4))
            0: return sb.thresh;
            1: return IR_W'((t > 0) ? t - 1 : 0);
            2: return IR_W'((t < 4095) ? t + 1 : 4095);
            3: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            default: return IR_W'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] dec,
                                logic [CFG_DATA_W-1:0] blk);
        wait_idle();
        cfg_write(CFG_THRESH, thr);
        cfg_write(CFG_DECIDE, dec);
        cfg_write(CFG_BLINK, blk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_byte(CH_F_UC);
        send_arrow(KEY_UP);
        send_arrow(KEY_LEFT);
        send_byte(CH_B_LC);
        send_byte(CH_S_UC);
        send_byte(CH_ESC);
        send_byte("x");
        send_arrow("Z");
        send_byte(CH_A_LC);
        send_byte(CH_L_UC);
        send_ir(12'd4095, 12'd0);
        send_tick();
        send_ir(sb.thresh, sb.thresh);
        offer(make_item(FUNC_NONE, 8'hFF, 12'hFFF, 12'hFFF));
        send_byte(CH_M_LC);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_ir(12'd0, 12'd4095);
        send_byte(CH_Q_LC);
    endtask

    task automatic run_random(int n_items);
        int start;
        int kind;
        int k;
        start = n_sent;
        while (n_sent - start < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                k = $urandom_range(0, 4);
                send_arrow((k == 0) ? KEY_UP : (k == 1) ? KEY_DOWN :
                           (k == 2) ? KEY_RIGHT : (k == 3) ? KEY_LEFT :
                           BYTE_W'($urandom));
            end else if (kind < 50) begin
                send_byte(letter_set[$urandom_range(0, 19)]);
            end else if (kind < 65) begin
                send_ir(pick_ir(), pick_ir());
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 30)) send_tick();
            end else if (kind < 94) begin
                send_byte(BYTE_W'($urandom));
            end else if (kind < 97) begin
                send_byte(CH_ESC);
                send_byte(BYTE_W'($urandom));
            end else begin
                send_none();
            end
        end
    endtask

    initial begin
        sb = new();
        n_sent = 0;
        n_results = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.func <= FUNC_BYTE;
        in_if.rx_byte <= '0;
        in_if.left_ir <= '0;
        in_if.right_ir <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_THRESH;
        cfg_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(255);

        program_regs(12'd0, 12'd0, 12'd0);
        run_random(255);

        program_regs(12'd4095, 12'd15, 12'd1023);
        run_random(255);

        program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     {2'(BAFT_W'($urandom) >> 8), 4'($urandom), 6'($urandom_range(0, 40))});
        wait_idle();
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        run_random(255);

        program_regs(12'd2048, 12'd3, 12'd1023);
        run_random(255);

        program_regs(12'd1500, 12'd10, 12'd500);
        run_random(255);

        in_if.valid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.drive_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
